FILE: rtl/cpu65_pkg.sv
// Shared types, operation codes and reset constants for the 6502 execute unit.
package cpu65_pkg;

    localparam int OP_W = 6;

    // Operation codes carried in the op field
    localparam logic [OP_W-1:0] OP_ADC = 6'd0;
    localparam logic [OP_W-1:0] OP_AND = 6'd1;
    localparam logic [OP_W-1:0] OP_ASL = 6'd2;
    localparam logic [OP_W-1:0] OP_BCC = 6'd3;
    localparam logic [OP_W-1:0] OP_BCS = 6'd4;
    localparam logic [OP_W-1:0] OP_BEQ = 6'd5;
    localparam logic [OP_W-1:0] OP_BIT = 6'd6;
    localparam logic [OP_W-1:0] OP_BMI = 6'd7;
    localparam logic [OP_W-1:0] OP_BNE = 6'd8;
    localparam logic [OP_W-1:0] OP_BPL = 6'd9;
    localparam logic [OP_W-1:0] OP_BVC = 6'd10;
    localparam logic [OP_W-1:0] OP_BVS = 6'd11;
    localparam logic [OP_W-1:0] OP_CLC = 6'd12;
    localparam logic [OP_W-1:0] OP_CLD = 6'd13;
    localparam logic [OP_W-1:0] OP_CLI = 6'd14;
    localparam logic [OP_W-1:0] OP_CLV = 6'd15;
    localparam logic [OP_W-1:0] OP_CMP = 6'd16;
    localparam logic [OP_W-1:0] OP_CPX = 6'd17;
    localparam logic [OP_W-1:0] OP_CPY = 6'd18;
    localparam logic [OP_W-1:0] OP_DEC = 6'd19;
    localparam logic [OP_W-1:0] OP_DEX = 6'd20;
    localparam logic [OP_W-1:0] OP_DEY = 6'd21;
    localparam logic [OP_W-1:0] OP_EOR = 6'd22;
    localparam logic [OP_W-1:0] OP_INC = 6'd23;
    localparam logic [OP_W-1:0] OP_INX = 6'd24;
    localparam logic [OP_W-1:0] OP_INY = 6'd25;
    localparam logic [OP_W-1:0] OP_JMP = 6'd26;
    localparam logic [OP_W-1:0] OP_LDA = 6'd27;
    localparam logic [OP_W-1:0] OP_LDX = 6'd28;
    localparam logic [OP_W-1:0] OP_LDY = 6'd29;
    localparam logic [OP_W-1:0] OP_LSR = 6'd30;
    localparam logic [OP_W-1:0] OP_NOP = 6'd31;
    localparam logic [OP_W-1:0] OP_ORA = 6'd32;
    localparam logic [OP_W-1:0] OP_ROL = 6'd33;
    localparam logic [OP_W-1:0] OP_ROR = 6'd34;
    localparam logic [OP_W-1:0] OP_SBC = 6'd35;
    localparam logic [OP_W-1:0] OP_SEC = 6'd36;
    localparam logic [OP_W-1:0] OP_SED = 6'd37;
    localparam logic [OP_W-1:0] OP_SEI = 6'd38;
    localparam logic [OP_W-1:0] OP_STA = 6'd39;
    localparam logic [OP_W-1:0] OP_STX = 6'd40;
    localparam logic [OP_W-1:0] OP_STY = 6'd41;
    localparam logic [OP_W-1:0] OP_TAX = 6'd42;
    localparam logic [OP_W-1:0] OP_TAY = 6'd43;
    localparam logic [OP_W-1:0] OP_TSX = 6'd44;
    localparam logic [OP_W-1:0] OP_TXA = 6'd45;
    localparam logic [OP_W-1:0] OP_TXS = 6'd46;
    localparam logic [OP_W-1:0] OP_TYA = 6'd47;
    localparam logic [OP_W-1:0] OP_LAX = 6'd48;
    localparam logic [OP_W-1:0] OP_SAX = 6'd49;
    localparam logic [OP_W-1:0] OP_DCP = 6'd50;

    // Status bit positions
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_D = 3;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    // NOP opcodes flagged as eligible for the page-cross penalty
    localparam logic [7:0] NOP_ZP   = 8'h04;
    localparam logic [7:0] NOP_AX_1 = 8'h1C;
    localparam logic [7:0] NOP_AX_3 = 8'h3C;
    localparam logic [7:0] NOP_AX_5 = 8'h5C;
    localparam logic [7:0] NOP_AX_7 = 8'h7C;
    localparam logic [7:0] NOP_AX_D = 8'hDC;
    localparam logic [7:0] NOP_AX_F = 8'hFC;

    localparam logic [7:0] SP_RESET     = 8'hFD;
    localparam logic [7:0] STATUS_RESET = 8'h24;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 80;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [7:0]         operand;
        logic               acc_mode;
        logic [15:0]        ea;
        logic signed [7:0]  rel;
        logic [15:0]        pc;
        logic [7:0]         opcode;
    } exec_in_t;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic [7:0] p;
    } cpu_state_t;

    typedef struct packed {
        logic        we;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [15:0] npc;
        logic [1:0]  bcy;
        logic        elig;
        logic [7:0]  acc;
        logic [7:0]  xreg;
        logic [7:0]  yreg;
        logic [7:0]  status;
    } exec_out_t;

endpackage

FILE: rtl/cpu65_exec.sv
// Single-pass execute logic: one decoded instruction against the register file.
module cpu65_exec
    import cpu65_pkg::*;
(
    input  exec_in_t   item,
    input  cpu_state_t st,
    output exec_out_t  res,
    output cpu_state_t st_next
);

    function automatic logic [7:0] with_nz(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] q;
        q         = p;
        q[FLAG_N] = v[7];
        q[FLAG_Z] = (v == 8'h00);
        return q;
    endfunction

    logic [7:0]  na, nx, ny, nsp, np;
    logic        we;
    logic [7:0]  wd;
    logic [15:0] npc;
    logic [1:0]  bcy;
    logic        elig;
    logic        shift_op;
    logic        take;
    logic        is_branch;
    logic [7:0]  r;
    logic        c_in;
    logic [7:0]  adc_m;
    logic [8:0]  sum9;
    logic [7:0]  adc_r;
    logic        adc_v;
    logic [7:0]  m_dec;
    logic [7:0]  m_inc;
    logic [7:0]  cmp_reg;
    logic [7:0]  cmp_m;
    logic [8:0]  diff9;
    logic [15:0] br_tgt;

    // Shared adder for ADC/SBC, shared subtractor for the compares
    always_comb
    begin
        c_in    = st.p[FLAG_C];
        adc_m   = (item.op == OP_SBC) ? ~item.operand : item.operand;
        sum9    = {1'b0, st.a} + {1'b0, adc_m} + {8'h00, c_in};
        adc_r   = sum9[7:0];
        adc_v   = (~(st.a[7] ^ adc_m[7])) & (st.a[7] ^ adc_r[7]);
        m_dec   = item.operand - 8'd1;
        m_inc   = item.operand + 8'd1;
        cmp_reg = (item.op == OP_CPX) ? st.x : ((item.op == OP_CPY) ? st.y : st.a);
        cmp_m   = (item.op == OP_DCP) ? m_dec : item.operand;
        diff9   = {1'b0, cmp_reg} - {1'b0, cmp_m};
        br_tgt  = item.pc + {{8{item.rel[7]}}, item.rel};
    end

    always_comb
    begin
        na        = st.a;
        nx        = st.x;
        ny        = st.y;
        nsp       = st.sp;
        np        = st.p;
        we        = 1'b0;
        wd        = 8'h00;
        npc       = item.pc;
        bcy       = 2'd0;
        elig      = 1'b0;
        shift_op  = 1'b0;
        take      = 1'b0;
        is_branch = 1'b0;
        r         = 8'h00;

        unique case (item.op) inside
            OP_ADC, OP_SBC:
            begin
                na            = adc_r;
                np            = with_nz(st.p, adc_r);
                np[FLAG_C]    = sum9[8];
                np[FLAG_V]    = adc_v;
                elig          = 1'b1;
            end
            OP_AND:
            begin
                na   = st.a & item.operand;
                np   = with_nz(st.p, na);
                elig = 1'b1;
            end
            OP_EOR:
            begin
                na   = st.a ^ item.operand;
                np   = with_nz(st.p, na);
                elig = 1'b1;
            end
            OP_ORA:
            begin
                na   = st.a | item.operand;
                np   = with_nz(st.p, na);
                elig = 1'b1;
            end
            OP_ASL:
            begin
                np[FLAG_C] = item.operand[7];
                r          = {item.operand[6:0], 1'b0};
                shift_op   = 1'b1;
            end
            OP_LSR:
            begin
                np[FLAG_C] = item.operand[0];
                r          = {1'b0, item.operand[7:1]};
                shift_op   = 1'b1;
            end
            OP_ROL:
            begin
                np[FLAG_C] = item.operand[7];
                r          = {item.operand[6:0], c_in};
                shift_op   = 1'b1;
            end
            OP_ROR:
            begin
                np[FLAG_C] = item.operand[0];
                r          = {c_in, item.operand[7:1]};
                shift_op   = 1'b1;
            end
            OP_BCC:
            begin
                is_branch = 1'b1;
                take      = ~st.p[FLAG_C];
            end
            OP_BCS:
            begin
                is_branch = 1'b1;
                take      = st.p[FLAG_C];
            end
            OP_BEQ:
            begin
                is_branch = 1'b1;
                take      = st.p[FLAG_Z];
            end
            OP_BNE:
            begin
                is_branch = 1'b1;
                take      = ~st.p[FLAG_Z];
            end
            OP_BMI:
            begin
                is_branch = 1'b1;
                take      = st.p[FLAG_N];
            end
            OP_BPL:
            begin
                is_branch = 1'b1;
                take      = ~st.p[FLAG_N];
            end
            OP_BVC:
            begin
                is_branch = 1'b1;
                take      = ~st.p[FLAG_V];
            end
            OP_BVS:
            begin
                is_branch = 1'b1;
                take      = st.p[FLAG_V];
            end
            OP_BIT:
            begin
                np[FLAG_Z] = ((st.a & item.operand) == 8'h00);
                np[FLAG_N] = item.operand[7];
                np[FLAG_V] = item.operand[6];
            end
            OP_CLC: np[FLAG_C] = 1'b0;
            OP_CLD: np[FLAG_D] = 1'b0;
            OP_CLI: np[FLAG_I] = 1'b0;
            OP_CLV: np[FLAG_V] = 1'b0;
            OP_SEC: np[FLAG_C] = 1'b1;
            OP_SED: np[FLAG_D] = 1'b1;
            OP_SEI: np[FLAG_I] = 1'b1;
            OP_CMP, OP_CPX, OP_CPY:
            begin
                np         = with_nz(st.p, diff9[7:0]);
                np[FLAG_C] = ~diff9[8];
                elig       = (item.op == OP_CMP);
            end
            OP_DCP:
            begin
                we         = 1'b1;
                wd         = m_dec;
                np         = with_nz(st.p, diff9[7:0]);
                np[FLAG_C] = ~diff9[8];
            end
            OP_DEC:
            begin
                we = 1'b1;
                wd = m_dec;
                np = with_nz(st.p, m_dec);
            end
            OP_INC:
            begin
                if (item.acc_mode)
                begin
                    na = st.a + 8'd1;
                    np = with_nz(st.p, na);
                end
                else
                begin
                    we = 1'b1;
                    wd = m_inc;
                    np = with_nz(st.p, m_inc);
                end
            end
            OP_DEX:
            begin
                nx = st.x - 8'd1;
                np = with_nz(st.p, nx);
            end
            OP_DEY:
            begin
                ny = st.y - 8'd1;
                np = with_nz(st.p, ny);
            end
            OP_INX:
            begin
                nx = st.x + 8'd1;
                np = with_nz(st.p, nx);
            end
            OP_INY:
            begin
                ny = st.y + 8'd1;
                np = with_nz(st.p, ny);
            end
            OP_JMP: npc = item.ea;
            OP_LDA:
            begin
                na   = item.operand;
                np   = with_nz(st.p, item.operand);
                elig = 1'b1;
            end
            OP_LDX:
            begin
                nx   = item.operand;
                np   = with_nz(st.p, item.operand);
                elig = 1'b1;
            end
            OP_LDY:
            begin
                ny   = item.operand;
                np   = with_nz(st.p, item.operand);
                elig = 1'b1;
            end
            OP_LAX:
            begin
                na   = item.operand;
                nx   = item.operand;
                np   = with_nz(st.p, item.operand);
                elig = 1'b1;
            end
            OP_NOP:
            begin
                elig = (item.opcode == NOP_ZP)   || (item.opcode == NOP_AX_1) ||
                       (item.opcode == NOP_AX_3) || (item.opcode == NOP_AX_5) ||
                       (item.opcode == NOP_AX_7) || (item.opcode == NOP_AX_D) ||
                       (item.opcode == NOP_AX_F);
            end
            OP_STA:
            begin
                we = 1'b1;
                wd = st.a;
            end
            OP_STX:
            begin
                we = 1'b1;
                wd = st.x;
            end
            OP_STY:
            begin
                we = 1'b1;
                wd = st.y;
            end
            OP_SAX:
            begin
                we = 1'b1;
                wd = st.a & st.x;
            end
            OP_TAX:
            begin
                nx = st.a;
                np = with_nz(st.p, st.a);
            end
            OP_TAY:
            begin
                ny = st.a;
                np = with_nz(st.p, st.a);
            end
            OP_TSX:
            begin
                nx = st.sp;
                np = with_nz(st.p, st.sp);
            end
            OP_TXA:
            begin
                na = st.x;
                np = with_nz(st.p, st.x);
            end
            OP_TYA:
            begin
                na = st.y;
                np = with_nz(st.p, st.y);
            end
            OP_TXS: nsp = st.x;
            default:
            begin
                // unused codes: no effect
                na = st.a;
            end
        endcase

        if (shift_op)
        begin
            np = with_nz(np, r);
            if (item.acc_mode)
            begin
                na = r;
            end
            else
            begin
                we = 1'b1;
                wd = r;
            end
        end

        if (is_branch && take)
        begin
            npc = br_tgt;
            bcy = (br_tgt[15:8] != item.pc[15:8]) ? 2'd2 : 2'd1;
        end
    end

    assign st_next.a  = na;
    assign st_next.x  = nx;
    assign st_next.y  = ny;
    assign st_next.sp = nsp;
    assign st_next.p  = np;

    assign res.we     = we;
    assign res.addr   = we ? item.ea : 16'h0000;
    assign res.data   = we ? wd : 8'h00;
    assign res.npc    = npc;
    assign res.bcy    = bcy;
    assign res.elig   = elig;
    assign res.acc    = na;
    assign res.xreg   = nx;
    assign res.yreg   = ny;
    assign res.status = np;

endmodule

FILE: rtl/cpu_6502_execute_unit_core.sv
// Top level of the 6502 execute unit: input stage, register file and result stage.
//
//  Channel  Direction  Beat contents
//  s_axis   in         one decoded instruction (op, operand, address, offset, pc, opcode)
//  m_axis   out        one result (memory write, next pc, cycle info, A X Y P)
//
//  Each beat is registered, executed combinationally against A/X/Y/SP/P and registered again:
//  one beat per cycle sustained while m_axis is ready.
//  The register file updates in the cycle the instruction moves into the result register,
//  so the next instruction sees it without a bubble.
//  Reset: A, X, Y = 0, SP = 0xFD, P = 0x24; both stages empty.
//  A stalled m_axis holds the result and the waiting input beat; the state does not move.
module cpu_6502_execute_unit_core
    import cpu65_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // op[5:0], operand[13:6], effective_address[29:14], rel_offset[37:30],
    // pc_in[53:38], opcode_byte[61:54], zero[63:62]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // accumulator_mode[0]
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // mem_write_enable[0], mem_write_address[16:1], mem_write_data[24:17],
    // next_pc[40:25], branch_cycles[42:41], page_penalty_eligible[43],
    // acc_out[51:44], xreg_out[59:52], yreg_out[67:60], status_out[75:68], zero[79:76]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic       s1_valid_reg;
    exec_in_t   s1_item_reg;
    exec_in_t   in_item;
    logic       out_valid_reg;
    exec_out_t  out_reg;
    cpu_state_t state_reg;
    cpu_state_t state_next;
    exec_out_t  exec_res;
    logic       out_ready;
    logic       exec_fire;
    logic       in_fire;

    assign in_item.op       = s_axis_tdata[5:0];
    assign in_item.operand  = s_axis_tdata[13:6];
    assign in_item.acc_mode = s_axis_tuser;
    assign in_item.ea       = s_axis_tdata[29:14];
    assign in_item.rel      = s_axis_tdata[37:30];
    assign in_item.pc       = s_axis_tdata[53:38];
    assign in_item.opcode   = s_axis_tdata[61:54];

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign exec_fire     = s1_valid_reg && out_ready;
    assign s_axis_tready = !s1_valid_reg || out_ready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    cpu65_exec u_exec
    (
        .item    (s1_item_reg),
        .st      (state_reg),
        .res     (exec_res),
        .st_next (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg.a   <= 8'h00;
            state_reg.x   <= 8'h00;
            state_reg.y   <= 8'h00;
            state_reg.sp  <= SP_RESET;
            state_reg.p   <= STATUS_RESET;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (exec_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (exec_fire)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload stages, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg <= in_item;
        end
        if (exec_fire)
        begin
            out_reg <= exec_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'h0, out_reg.status, out_reg.yreg, out_reg.xreg, out_reg.acc,
                            out_reg.elig, out_reg.bcy, out_reg.npc, out_reg.data,
                            out_reg.addr, out_reg.we};

`ifndef SYNTHESIS
    // a stalled result freezes the register file
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(state_reg))
        else $error("register file moved while result stalled");

    // unused status bits keep their reset pattern
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.p[5] == 1'b1) && (state_reg.p[4] == 1'b0))
        else $error("status bits 5/4 changed");

    // executed instruction always lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire |=> (m_axis_tvalid && (out_reg.acc == state_reg.a)
                       && (out_reg.status == state_reg.p)))
        else $error("result and register file disagree");

    // no write means address and data read as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !out_reg.we) |-> ((out_reg.addr == 16'h0000)
                                            && (out_reg.data == 8'h00)))
        else $error("write fields set without a write");
`endif

endmodule
